>>> hdl/kal_pkg.sv
// Shared constants, types and character helpers for the key allowlist block.
package kal_pkg;

  localparam int unsigned MAX_KEYS = 16;
  localparam int unsigned CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int unsigned IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned KEY_W    = 256;

  localparam logic [1:0] FUNC_CHAR  = 2'd0;
  localparam logic [1:0] FUNC_END   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_TOOMANY = 2'd2;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;

  localparam logic [6:0] PREFIX_LEN = 7'd8;
  localparam logic [6:0] NONE_LEN   = 7'd4;
  localparam logic [6:0] KEY_LEN    = 7'd72;
  localparam logic [6:0] LEN_SAT    = 7'd127;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  typedef struct packed {
    logic              none_ok;
    logic              key_ok;
    logic [KEY_W-1:0]  key;
  } entry_t;

  function automatic logic [7:0] none_char(input logic [1:0] p);
    logic [7:0] c;
    unique case (p)
      2'd0: c = "n";
      2'd1: c = "o";
      2'd2: c = "n";
      default: c = "e";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    logic [7:0] c;
    unique case (p)
      3'd0: c = "n";
      3'd1: c = "o";
      3'd2: c = "d";
      3'd3: c = "e";
      3'd4: c = "k";
      3'd5: c = "e";
      3'd6: c = "y";
      default: c = ":";
    endcase
    return c;
  endfunction

  // bit 4 flags a hex digit, low nibble is its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    else r = 5'd0;
    return r;
  endfunction

endpackage

>>> hdl/kal_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
module kal_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 256,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/kal_entry.sv
// Entry parser: trims blanks, checks "none" / "nodekey:" and assembles hex key.
module kal_entry (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          char_en_i,
  input  logic [7:0]    ch_i,
  input  logic          clr_i,
  output kal_pkg::entry_t entry_o
);
  import kal_pkg::*;

  logic [1:0]       phase_q, phase_d;
  logic [6:0]       len_q, len_d;
  logic             fl_prefix_q, fl_prefix_d;
  logic             fl_none_q, fl_none_d;
  logic             fl_hex_q, fl_hex_d;
  logic [KEY_W-1:0] asm_q, asm_d;
  logic             blank;
  logic             body;
  logic [4:0]       nib;

  assign blank = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
  assign nib   = hex_nibble(ch_i);

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    fl_prefix_d = fl_prefix_q;
    fl_none_d   = fl_none_q;
    fl_hex_d    = fl_hex_q;
    asm_d       = asm_q;
    body        = 1'b0;
    if (clr_i) begin
      phase_d     = PH_LEAD;
      len_d       = '0;
      fl_prefix_d = 1'b1;
      fl_none_d   = 1'b1;
      fl_hex_d    = 1'b1;
      asm_d       = '0;
    end else if (char_en_i) begin
      unique case (phase_q)
        PH_LEAD: begin
          if (!blank) begin
            phase_d = PH_BODY;
            body    = 1'b1;
          end
        end
        PH_BODY: begin
          if (blank) phase_d = PH_TRAIL;
          else body = 1'b1;
        end
        default: begin
          if (!blank) begin
            fl_prefix_d = 1'b0;
            fl_none_d   = 1'b0;
            fl_hex_d    = 1'b0;
          end
        end
      endcase
      if (body) begin
        if (len_q < NONE_LEN) begin
          if (ch_i != none_char(len_q[1:0])) fl_none_d = 1'b0;
        end else begin
          fl_none_d = 1'b0;
        end
        if (len_q < PREFIX_LEN) begin
          if (ch_i != prefix_char(len_q[2:0])) fl_prefix_d = 1'b0;
        end else if (len_q < KEY_LEN) begin
          if (!nib[4]) fl_hex_d = 1'b0;
          else asm_d = {asm_q[KEY_W-5:0], nib[3:0]};
        end
        if (len_q < LEN_SAT) len_d = len_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      len_q       <= '0;
      fl_prefix_q <= 1'b1;
      fl_none_q   <= 1'b1;
      fl_hex_q    <= 1'b1;
      asm_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      fl_prefix_q <= fl_prefix_d;
      fl_none_q   <= fl_none_d;
      fl_hex_q    <= fl_hex_d;
      asm_q       <= asm_d;
    end
  end

  assign entry_o.none_ok = (len_q == NONE_LEN) && fl_none_q;
  assign entry_o.key_ok  = (len_q == KEY_LEN) && fl_prefix_q && fl_hex_q;
  assign entry_o.key     = asm_q;

endmodule

>>> hdl/key_allowlist_parser_matcher_core.sv
// Top level: spec sequencer, key table scan and result register.
//
//  channel | handshake              | payload
//  in      | in_valid_i / in_ready_o  | func_i ch_i key_w0_i..key_w3_i
//  out     | out_valid_o / out_ready_i| kind_o status_o permitted_o
//
// A spec character is handled as it is accepted, and the block stays ready. A comma
// or end of spec that closes a key entry, and a permit query on an active list,
// scan the key table through the RAM read port and then pass through the finish
// state. Any other end of spec or query goes from the accept straight to the
// finish state.
// Reset clears all control state; table contents are unknown but never read
// past key_count. A stalled output beat holds an end of spec or query in its finish state.
module key_allowlist_parser_matcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  ch_i,
  input  logic [63:0] key_w0_i,
  input  logic [63:0] key_w1_i,
  input  logic [63:0] key_w2_i,
  input  logic [63:0] key_w3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [1:0]  status_o,
  output logic        permitted_o
);
  import kal_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             rd_v_q, rd_v_d;
  logic             hit_q, hit_d;
  logic             active_q, active_d;
  logic             any_q, any_d;
  logic [1:0]       spec_st_q, spec_st_d;
  logic             m_add_q, m_add_d;
  logic             m_end_q, m_end_d;
  logic             m_qry_q, m_qry_d;
  logic [1:0]       res_st_q, res_st_d;
  logic             res_perm_q, res_perm_d;
  logic [KEY_W-1:0] qkey_q, qkey_d;
  logic             out_v_q, out_v_d;
  logic             kind_q, kind_d;
  logic [1:0]       ost_q, ost_d;
  logic             perm_q, perm_d;

  logic             accept, out_free, is_zero;
  logic             char_en, ent_clr;
  logic             re, we;
  logic [KEY_W-1:0] rdata, cmp_key;
  logic [1:0]       fst;
  entry_t           ent;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_v_q || out_ready_i;
  assign is_zero    = ({key_w0_i, key_w1_i, key_w2_i, key_w3_i} == '0);
  assign cmp_key    = m_qry_q ? qkey_q : ent.key;

  kal_entry u_entry (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_en_i (char_en),
    .ch_i      (ch_i),
    .clr_i     (ent_clr),
    .entry_o   (ent)
  );

  kal_ram #(
    .DEPTH  (MAX_KEYS),
    .WIDTH  (KEY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (ent.key),
    .re_i    (re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    rd_v_d     = 1'b0;
    hit_d      = hit_q;
    active_d   = active_q;
    any_d      = any_q;
    spec_st_d  = spec_st_q;
    m_add_d    = m_add_q;
    m_end_d    = m_end_q;
    m_qry_d    = m_qry_q;
    res_st_d   = res_st_q;
    res_perm_d = res_perm_q;
    qkey_d     = qkey_q;
    out_v_d    = out_v_q && !out_ready_i;
    kind_d     = kind_q;
    ost_d      = ost_q;
    perm_d     = perm_q;
    char_en    = 1'b0;
    ent_clr    = 1'b0;
    re         = 1'b0;
    we         = 1'b0;
    fst        = res_st_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          m_add_d    = 1'b0;
          m_end_d    = 1'b0;
          m_qry_d    = 1'b0;
          res_st_d   = STAT_OK;
          res_perm_d = 1'b0;
          hit_d      = 1'b0;
          idx_d      = '0;
          unique case (func_i)
            FUNC_CHAR: begin
              any_d = 1'b1;
              if (spec_st_q == STAT_OK) begin
                if (ch_i == CH_COMMA) begin
                  if (ent.none_ok) begin
                    ent_clr = 1'b1;
                  end else if (ent.key_ok) begin
                    m_add_d = 1'b1;
                    state_d = S_SCAN;
                  end else begin
                    spec_st_d = STAT_INVALID;
                    ent_clr   = 1'b1;
                  end
                end else begin
                  char_en = 1'b1;
                end
              end
            end
            FUNC_END: begin
              m_end_d = 1'b1;
              state_d = S_FIN;
              if (!any_q) begin
                res_st_d = STAT_INVALID;
              end else if (spec_st_q != STAT_OK) begin
                res_st_d = spec_st_q;
              end else if (ent.none_ok) begin
                res_st_d = STAT_OK;
              end else if (ent.key_ok) begin
                m_add_d = 1'b1;
                state_d = S_SCAN;
              end else begin
                res_st_d = STAT_INVALID;
              end
            end
            FUNC_QUERY: begin
              m_qry_d = 1'b1;
              qkey_d  = {key_w0_i, key_w1_i, key_w2_i, key_w3_i};
              if (is_zero) begin
                state_d = S_FIN;
              end else if (!active_q) begin
                res_perm_d = 1'b1;
                state_d    = S_FIN;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (idx_q != count_q) begin
          re     = 1'b1;
          rd_v_d = 1'b1;
          idx_d  = idx_q + CNT_W'(1);
        end
        if (rd_v_q && (rdata == cmp_key)) hit_d = 1'b1;
        if (idx_q == count_q && !rd_v_q) state_d = S_FIN;
      end

      default: begin
        if (!((m_end_q || m_qry_q) && !out_free)) begin
          if (m_add_q) begin
            if (hit_q) begin
              fst = STAT_OK;
            end else if (count_q == CNT_W'(MAX_KEYS)) begin
              fst = STAT_TOOMANY;
            end else begin
              fst     = STAT_OK;
              we      = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
          if (m_end_q) begin
            out_v_d   = 1'b1;
            kind_d    = 1'b0;
            ost_d     = fst;
            perm_d    = 1'b0;
            if (fst == STAT_OK) active_d = 1'b1;
            any_d     = 1'b0;
            spec_st_d = STAT_OK;
            ent_clr   = 1'b1;
          end else if (m_add_q) begin
            spec_st_d = fst;
            ent_clr   = 1'b1;
          end
          if (m_qry_q) begin
            out_v_d = 1'b1;
            kind_d  = 1'b1;
            ost_d   = STAT_OK;
            perm_d  = res_perm_q || hit_q;
          end
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      rd_v_q    <= 1'b0;
      hit_q     <= 1'b0;
      active_q  <= 1'b0;
      any_q     <= 1'b0;
      spec_st_q <= STAT_OK;
      m_add_q   <= 1'b0;
      m_end_q   <= 1'b0;
      m_qry_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_v_q    <= rd_v_d;
      hit_q     <= hit_d;
      active_q  <= active_d;
      any_q     <= any_d;
      spec_st_q <= spec_st_d;
      m_add_q   <= m_add_d;
      m_end_q   <= m_end_d;
      m_qry_q   <= m_qry_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_st_q   <= res_st_d;
    res_perm_q <= res_perm_d;
    qkey_q     <= qkey_d;
    kind_q     <= kind_d;
    ost_q      <= ost_d;
    perm_q     <= perm_d;
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = kind_q;
  assign status_o    = ost_q;
  assign permitted_o = perm_q;

endmodule

>>> tb/sv/tb.sv
// Testbench for the key allowlist parser and matcher: directed and random spec and query beats, scoreboard check.
`timescale 1ns / 100ps

module tb;
  import kal_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_CHAR;
  logic [7:0]  ch_i = 8'd0;
  logic [63:0] key_w0_i = '0;
  logic [63:0] key_w1_i = '0;
  logic [63:0] key_w2_i = '0;
  logic [63:0] key_w3_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [1:0]  status_o;
  logic        permitted_o;

  typedef struct {
    logic       kind;
    logic [1:0] status;
    logic       permitted;
  } answer_t;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  key_allowlist_parser_matcher_core dut (.*);

  // Shadow allowlist: parses spec beats and queues the answers the block owes.
  class allowlist_scoreboard;
    logic [KEY_W-1:0] keys[$];
    bit         active;
    bit         any_char;
    logic [1:0] spec_st;
    logic [1:0] phase;
    int         len;
    bit         f_prefix, f_none, f_hex;
    logic [KEY_W-1:0] acc;
    answer_t    pending[$];
    int         mismatches;

    function void clear_entry();
      phase = PH_LEAD;
      len = 0;
      f_prefix = 1; f_none = 1; f_hex = 1;
      acc = '0;
    endfunction

    function void reset_state();
      keys.delete();
      active = 0;
      any_char = 0;
      spec_st = STAT_OK;
      pending.delete();
      clear_entry();
    endfunction

    function logic [1:0] store_key();
      foreach (keys[i]) if (keys[i] == acc) return STAT_OK;
      if (keys.size() >= MAX_KEYS) return STAT_TOOMANY;
      keys.push_back(acc);
      return STAT_OK;
    endfunction

    function logic [1:0] close_entry();
      logic [1:0] st;
      if (len == 4 && f_none) st = STAT_OK;
      else if (len == 72 && f_prefix && f_hex) st = store_key();
      else st = STAT_INVALID;
      clear_entry();
      return st;
    endfunction

    function void body_char(logic [7:0] c);
      string nw, pw;
      int v;
      nw = "none";
      pw = "nodekey:";
      if (len < 4) begin
        if (c != nw[len]) f_none = 0;
      end else f_none = 0;
      if (len < 8) begin
        if (c != pw[len]) f_prefix = 0;
      end else if (len < 72) begin
        v = -1;
        if (c >= "0" && c <= "9") v = c - "0";
        else if (c >= "a" && c <= "f") v = c - "a" + 10;
        else if (c >= "A" && c <= "F") v = c - "A" + 10;
        if (v < 0) f_hex = 0;
        else acc = {acc[KEY_W-5:0], 4'(v)};
      end
      if (len < 127) len++;
    endfunction

    function void note_beat(logic [1:0] f, logic [7:0] c, logic [KEY_W-1:0] q);
      answer_t a;
      bit blank;
      bit hit;
      if (f == FUNC_CHAR) begin
        blank = (c == CH_SPACE || c == CH_TAB);
        any_char = 1;
        if (spec_st != STAT_OK) return;
        if (c == CH_COMMA) spec_st = close_entry();
        else if (phase == PH_LEAD) begin
          if (!blank) begin
            phase = PH_BODY;
            body_char(c);
          end
        end else if (phase == PH_BODY) begin
          if (blank) phase = PH_TRAIL;
          else body_char(c);
        end else if (!blank) begin
          f_prefix = 0; f_none = 0; f_hex = 0;
        end
      end else if (f == FUNC_END) begin
        a.status = spec_st;
        if (!any_char) a.status = STAT_INVALID;
        else if (a.status == STAT_OK) a.status = close_entry();
        if (a.status == STAT_OK) active = 1;
        a.kind = 1'b0;
        a.permitted = 1'b0;
        pending.push_back(a);
        any_char = 0;
        spec_st = STAT_OK;
        clear_entry();
      end else if (f == FUNC_QUERY) begin
        hit = 0;
        if (q == '0) hit = 0;
        else if (!active) hit = 1;
        else foreach (keys[i]) if (keys[i] == q) hit = 1;
        a.kind = 1'b1;
        a.status = STAT_OK;
        a.permitted = hit;
        pending.push_back(a);
      end
    endfunction

    function void check_answer(logic k, logic [1:0] s, logic p);
      answer_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind=%0d status=%0d permitted=%0d",
                                       k, s, p);
        return;
      end
      e = pending.pop_front();
      if (e.kind !== k || e.status !== s || e.permitted !== p) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp kind=%0d status=%0d permitted=%0d, got %0d %0d %0d",
                   e.kind, e.status, e.permitted, k, s, p);
      end
    endfunction
  endclass

  allowlist_scoreboard sb;
  int idle_cycles;
  int beats_sent;
  logic [KEY_W-1:0] known_keys[$];

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_beat(func_i, ch_i, {key_w0_i, key_w1_i, key_w2_i, key_w3_i});
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_answer(kind_o, status_o, permitted_o);
  end

  // Output stall: a random number of low cycles before each accepted beat.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] f, logic [7:0] c, logic [KEY_W-1:0] q);
    int w;
    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (w > 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    ch_i <= c;
    {key_w0_i, key_w1_i, key_w2_i, key_w3_i} <= q;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_beat(FUNC_CHAR, s[i], '0);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    for (int i = 0; i < 8; i++) k[i*32 +: 32] = $urandom();
    if ($urandom_range(0, 5) == 0) k[KEY_W-1 -: 32] = 32'hffff_ffff;
    if ($urandom_range(0, 5) == 0) k[KEY_W-1 -: 32] = 32'h0;
    return k;
  endfunction

  function automatic string key_text(logic [KEY_W-1:0] k, bit mixed);
    string s, d;
    s = "nodekey:";
    for (int i = 63; i >= 0; i--) begin
      d = $sformatf("%h", k[i*4 +: 4]);
      if (mixed && $urandom_range(0, 1)) d = d.toupper();
      s = {s, d};
    end
    return s;
  endfunction

  function automatic string pad();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, ($urandom_range(0, 1) ? " " : "\t")};
    return s;
  endfunction

  // One random entry: mostly well formed, sometimes damaged.
  function automatic string random_entry();
    logic [KEY_W-1:0] k;
    string s;
    int r, p;
    r = $urandom_range(0, 19);
    if (r < 2) return {pad(), "none", pad()};
    if (known_keys.size() > 0 && r < 6)
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
    else begin
      k = random_key();
      known_keys.push_back(k);
    end
    s = key_text(k, 1'($urandom_range(0, 1)));
    if (r == 17) s = s.substr(0, $urandom_range(0, 70));
    if (r == 18) begin
      p = $urandom_range(0, 71);
      s[p] = 8'($urandom_range(1, 255));
      if (s[p] == ",") s[p] = "g";
    end
    if (r == 19) s = {s, " x"};
    return {pad(), s, pad()};
  endfunction

  task automatic send_query(bit known);
    logic [KEY_W-1:0] q;
    if (known && known_keys.size() > 0) q = known_keys[$urandom_range(0, known_keys.size() - 1)];
    else if ($urandom_range(0, 15) == 0) q = '0;
    else q = random_key();
    send_beat(FUNC_QUERY, 8'($urandom_range(0, 255)), q);
  endtask

  initial begin
    string s;
    int n;
    sb = new();
    sb.reset_state();
    sb.mismatches = 0;
    idle_cycles = 0;
    beats_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty spec, all-zero and inactive queries, ignored func, odd chars
    send_beat(FUNC_END, 8'd0, '0);
    send_query(0);
    send_beat(FUNC_QUERY, 8'd0, '0);
    send_beat(FUNC_QUERY, 8'd0, '1);
    send_beat(2'd3, 8'hff, '1);
    send_text(" \tnone\t ");
    send_query(0);
    send_beat(FUNC_END, 8'd0, '0);
    send_text("no ne");
    send_beat(FUNC_END, 8'd0, '0);
    send_beat(FUNC_CHAR, 8'hff, '0);
    send_beat(FUNC_CHAR, 8'd0, '0);
    send_beat(FUNC_END, 8'd0, '0);
    send_text("none,,");
    send_beat(FUNC_END, 8'd0, '0);
    send_query(1);

    // random specs with queries interleaved
    while (beats_sent < 950) begin
      n = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 4);
      s = "";
      for (int i = 0; i < n; i++) s = {s, (i > 0) ? "," : "", random_entry()};
      if ($urandom_range(0, 19) == 0) s = {s, ","};
      foreach (s[i]) begin
        if (beats_sent >= 940) break;
        send_beat(FUNC_CHAR, s[i], random_key());
        if ($urandom_range(0, 60) == 0) send_query(1'($urandom_range(0, 1)));
      end
      send_beat(FUNC_END, 8'($urandom_range(0, 255)), '0);
      repeat ($urandom_range(1, 4)) send_query($urandom_range(0, 2) != 0);
    end
    in_valid_i <= 1'b0;

    n = 0;
    while (sb.pending.size() > 0 && n < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

>>> key_allowlist_parser_matcher_core.f
hdl/kal_pkg.sv
hdl/kal_ram.sv
hdl/kal_entry.sv
hdl/key_allowlist_parser_matcher_core.sv
tb/sv/tb.sv
